FILE: src/pscs_pkg.sv
// Shared types and constants for the per-thread shadow call stack.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package pscs_pkg;

   localparam int MODE_W     = 3;
   localparam int THREAD_W   = 3;
   localparam int FUNC_W     = 16;
   localparam int FRAME_W    = 48;
   localparam int STATUS_W   = 2;
   localparam int PRUNE_W    = 7;
   localparam int THREADS_DEF = 8;
   localparam int DEPTH_DEF   = 64;

   localparam logic [PRUNE_W-1:0] PRUNE_MAX = '1;

   // mode codes; unused codes behave as peek
   typedef enum logic [MODE_W-1:0] {
      OP_PUSH    = 3'd0,
      OP_CHK_POP = 3'd1,
      OP_POP     = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_PEEK    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_MISMATCH  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_PRUNE,
      S_STORE,
      S_CHECK,
      S_FETCH,
      S_TOP,
      S_RESULT
   } state_type;

   // one call record, as held in the stack memory
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [FRAME_W-1:0] frame;
   } rec_type;

endpackage

FILE: src/pscs_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pscs_pkg for the field widths.
`timescale 1ns / 1ps

interface pscs_req_if;
   logic                           valid;
   logic                           ready;
   logic [pscs_pkg::MODE_W-1:0]    mode;
   logic [pscs_pkg::THREAD_W-1:0]  thread_index;
   logic [pscs_pkg::FUNC_W-1:0]    func_id;
   logic [pscs_pkg::FRAME_W-1:0]   frame_base;

   modport source (output valid, mode, thread_index, func_id, frame_base, input ready);
   modport sink   (input valid, mode, thread_index, func_id, frame_base, output ready);
endinterface

interface pscs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pscs_pkg::STATUS_W-1:0]  status;
   logic                           is_empty;
   logic [pscs_pkg::FUNC_W-1:0]    top_func;
   logic [pscs_pkg::FRAME_W-1:0]   top_frame;
   logic [pscs_pkg::PRUNE_W-1:0]   pruned_count;

   modport source (output valid, status, is_empty, top_func, top_frame, pruned_count,
                   input ready);
   modport sink   (input valid, status, is_empty, top_func, top_frame, pruned_count,
                   output ready);
endinterface

FILE: src/per_thread_shadow_call_stack.sv
// Per-thread shadow call stack: one bounded stack of call records per thread.
// Depends on pscs_pkg and the channel interfaces in pscs_if.sv.
//
// Usage
//   req (sink): mode, thread_index, func_id, frame_base. An item is taken when
//   req.valid and req.ready are both high. rsp (source): status, is_empty,
//   top_func, top_frame, pruned_count; exactly one result per request item.
//   One item is worked on at a time. After it is accepted, an item passes
//   dispatch and then, as its mode needs, pruning, the store, the check of the
//   popped record, the depth update and the read-back of the new top before
//   its result is loaded into the output register; a thread out of range goes
//   straight from dispatch to the result. The steps come from the single
//   registered read port: pruning walks one record per cycle; the new top is
//   read after the update. The output register lets a new item be taken while
//   a result waits; if the receiver stalls, the next result waits in the
//   result state and no further item is taken.
//   Reset clears all stack depths and the control state at once; the memory is
//   not cleared, since only entries below a thread's depth are ever used.
`timescale 1ns / 1ps

module per_thread_shadow_call_stack #(
   parameter int THREADS = pscs_pkg::THREADS_DEF,
   parameter int DEPTH   = pscs_pkg::DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   pscs_req_if.sink            req,
   pscs_rsp_if.source          rsp
);
   import pscs_pkg::*;

   localparam int TW   = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int IW   = $clog2(DEPTH);
   localparam int DW   = $clog2(DEPTH + 1);
   localparam int AW   = $clog2(THREADS * DEPTH);
   localparam int TC_W = 7;

   state_type           state_ff, state_in;
   op_type              mode_ff, mode_in;
   logic [THREAD_W-1:0] t_ff, t_in;
   logic [FUNC_W-1:0]   fid_ff, fid_in;
   logic [FRAME_W-1:0]  fb_ff, fb_in;
   logic [DW-1:0]       d_ff, d_in;
   logic [PRUNE_W-1:0]  pruned_ff, pruned_in;
   status_type          status_ff, status_in;
   logic                empty_ff, empty_in;
   rec_type             top_ff, top_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_empty_ff, rsp_empty_in;
   rec_type             rsp_top_ff, rsp_top_in;
   logic [PRUNE_W-1:0]  rsp_pruned_ff, rsp_pruned_in;

   logic [DW-1:0]       depth_ff [THREADS];
   logic [DW-1:0]       depth_in [THREADS];

   rec_type             stack_mem [THREADS*DEPTH];
   rec_type             rd_data_ff;

   logic [TW-1:0]       t_idx;
   logic                t_ok;
   logic [AW-1:0]       base;
   logic [DW-1:0]       rd_pos;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   logic                clear_all;
   logic                commit;

   assign t_idx   = TW'(t_ff);
   assign t_ok    = (TC_W'(t_ff) < TC_W'(THREADS));
   assign base    = AW'(t_idx) * AW'(DEPTH);
   // while pruning, the next read is already one below the record under test
   assign rd_pos  = (state_ff == S_PRUNE) ? (d_ff - DW'(2)) : (d_ff - DW'(1));
   assign rd_addr = base + AW'(IW'(rd_pos));
   assign wr_addr = base + AW'(IW'(d_ff));

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      t_in          = t_ff;
      fid_in        = fid_ff;
      fb_in         = fb_ff;
      d_in          = d_ff;
      pruned_in     = pruned_ff;
      status_in     = status_ff;
      empty_in      = empty_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_pruned_in = rsp_pruned_ff;
      wr_en         = 1'b0;
      clear_all     = 1'b0;
      commit        = 1'b0;
      req.ready     = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in   = op_type'(req.mode);
               t_in      = req.thread_index;
               fid_in    = req.func_id;
               fb_in     = req.frame_base;
               d_in      = depth_ff[TW'(req.thread_index)];
               pruned_in = '0;
               status_in = ST_OK;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!t_ok) begin
               empty_in = 1'b1;
               top_in   = '0;
               state_in = S_RESULT;
            end else begin
               case (mode_ff)
                  OP_PUSH: begin
                     state_in = (d_ff != '0) ? S_PRUNE : S_STORE;
                  end
                  OP_CHK_POP: begin
                     if (d_ff == '0) begin
                        status_in = ST_UNDERFLOW;
                        state_in  = S_FETCH;
                     end else begin
                        state_in  = S_CHECK;
                     end
                  end
                  OP_POP: begin
                     if (d_ff == '0) status_in = ST_UNDERFLOW;
                     else d_in = d_ff - DW'(1);
                     state_in = S_FETCH;
                  end
                  OP_CLEAR: begin
                     clear_all = 1'b1;
                     d_in      = '0;
                     state_in  = S_FETCH;
                  end
                  default: begin
                     state_in = S_FETCH;
                  end
               endcase
            end
         end
         S_PRUNE: begin
            // stale frame: discard it and test the one below next cycle
            if (rd_data_ff.frame <= fb_ff) begin
               d_in = d_ff - DW'(1);
               if (pruned_ff != PRUNE_MAX) pruned_in = pruned_ff + PRUNE_W'(1);
               state_in = (d_ff != DW'(1)) ? S_PRUNE : S_STORE;
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            if (d_ff == DW'(DEPTH)) begin
               status_in = ST_OVERFLOW;
            end else begin
               wr_en = 1'b1;
               d_in  = d_ff + DW'(1);
            end
            state_in = S_FETCH;
         end
         S_CHECK: begin
            if (rd_data_ff.func != fid_ff || rd_data_ff.frame != fb_ff)
               status_in = ST_MISMATCH;
            d_in     = d_ff - DW'(1);
            state_in = S_FETCH;
         end
         S_FETCH: begin
            commit = 1'b1;
            if (d_ff == '0) begin
               empty_in = 1'b1;
               top_in   = '0;
               state_in = S_RESULT;
            end else begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            empty_in = 1'b0;
            top_in   = rd_data_ff;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_empty_in  = empty_ff;
               rsp_top_in    = top_ff;
               rsp_pruned_in = pruned_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < THREADS; i++) begin
         depth_in[i] = depth_ff[i];
         if (clear_all) depth_in[i] = '0;
      end
      if (commit) depth_in[t_idx] = d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         d_ff         <= '0;
         for (int i = 0; i < THREADS; i++) depth_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
         for (int i = 0; i < THREADS; i++) depth_ff[i] <= depth_in[i];
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      t_ff          <= t_in;
      fid_ff        <= fid_in;
      fb_ff         <= fb_in;
      pruned_ff     <= pruned_in;
      status_ff     <= status_in;
      empty_ff      <= empty_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_pruned_ff <= rsp_pruned_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= '{func: fid_ff, frame: fb_ff};
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.is_empty     = rsp_empty_ff;
   assign rsp.top_func     = rsp_top_ff.func;
   assign rsp.top_frame    = rsp_top_ff.frame;
   assign rsp.pruned_count = rsp_pruned_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("item taken while another is in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (d_ff <= DW'(DEPTH)))
      else $error("stack depth beyond capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_OVERFLOW) |-> !rsp.is_empty)
      else $error("overflow reported on an empty stack");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_UNDERFLOW) |-> (rsp.is_empty && rsp.pruned_count == '0))
      else $error("underflow reported on a non-empty stack");

endmodule

FILE: tb/per_thread_shadow_call_stack_tb.sv
// Self-checking testbench for the per-thread shadow call stack.
// Depends on pscs_pkg, the channel interfaces in pscs_if.sv and the block itself;
// a directed table is run first, then random call/return traffic per thread.
`timescale 1ns / 1ps

module per_thread_shadow_call_stack_tb;
   import pscs_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 12;
   localparam int THREADS        = THREADS_DEF;
   localparam int DEPTH          = DEPTH_DEF;
   localparam int PHASE_ITEMS    = 440;
   localparam int LONG_HOLD      = 400;
   localparam int MAX_GAP        = 20;
   localparam int TAIL_CYCLES    = 2 * DEPTH + 16;
   localparam int WATCHDOG_LIMIT = 4000;

   // mode codes with no operation of their own; the block treats them as peek
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [THREAD_W-1:0] thread;
      logic [FUNC_W-1:0]   func;
      logic [FRAME_W-1:0]  frame;
   } call_op_type;

   typedef struct packed {
      status_type          status;
      logic                is_empty;
      logic [FUNC_W-1:0]   top_func;
      logic [FRAME_W-1:0]  top_frame;
      logic [PRUNE_W-1:0]  pruned_count;
   } stack_result_type;

   typedef struct {
      call_op_type      op;
      int               reps;
      bit               known;
      stack_result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pscs_req_if req_ch ();
   pscs_rsp_if rsp_ch ();

   per_thread_shadow_call_stack u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor copy of the stacks
   rec_type          call_mem [THREADS][DEPTH];
   int               call_depth [THREADS];
   stack_result_type pending_results [$];
   directed_row_type directed_rows [$];

   int tx_idle_pct = 8;
   int rx_idle_pct = 80;
   int hold_asked  = 0;
   int hold_done   = 0;
   int hold_left   = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int n_items = 0;
   int n_checked = 0;
   int max_pruned = 0;
   int peak_depth = 0;
   int status_seen [4] = '{default: 0};
   stack_result_type oldest;

   function automatic stack_result_type apply_call_op(input call_op_type op);
      stack_result_type r;
      int t;
      int d;
      int n_pruned;
      t = int'(op.thread);
      d = call_depth[t];
      n_pruned = 0;
      r = '0;
      r.status = ST_OK;
      case (op.mode)
         OP_PUSH: begin
            // stale frames sit at or below the new base on a down-growing stack
            while (d > 0 && call_mem[t][d-1].frame <= op.frame) begin
               d--;
               n_pruned++;
            end
            if (d >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               call_mem[t][d] = {op.func, op.frame};
               d++;
            end
         end
         OP_CHK_POP: begin
            if (d == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               if (call_mem[t][d-1] != {op.func, op.frame})
                  r.status = ST_MISMATCH;
               d--;
            end
         end
         OP_POP: begin
            if (d == 0)
               r.status = ST_UNDERFLOW;
            else
               d--;
         end
         OP_CLEAR: begin
            foreach (call_depth[i])
               call_depth[i] = 0;
            d = 0;
         end
         default: ;
      endcase
      call_depth[t] = d;
      if (d > peak_depth)
         peak_depth = d;
      r.is_empty = (d == 0);
      if (d > 0) begin
         r.top_func  = call_mem[t][d-1].func;
         r.top_frame = call_mem[t][d-1].frame;
      end
      r.pruned_count = (n_pruned > PRUNE_MAX) ? PRUNE_MAX : PRUNE_W'(n_pruned);
      return r;
   endfunction

   function automatic logic [FRAME_W-1:0] rand_frame();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[FRAME_W-1:0];
   endfunction

   // a call one level deeper: frame just below the current top
   function automatic call_op_type nested_push(input int t);
      call_op_type op;
      logic [FRAME_W-1:0] step;
      logic [FRAME_W-1:0] top;
      op.mode   = OP_PUSH;
      op.thread = THREAD_W'(t);
      op.func   = FUNC_W'($urandom);
      step      = FRAME_W'($urandom_range(1, 'hFFFF));
      if (call_depth[t] == 0) begin
         op.frame = rand_frame();
         op.frame[FRAME_W-1] = 1'b1;
      end else begin
         top = call_mem[t][call_depth[t]-1].frame;
         op.frame = (top > step) ? top - step : top;
      end
      return op;
   endfunction

   function automatic call_op_type pick_call_op();
      call_op_type op;
      logic [63:0] rec_bits;
      int t;
      int d;
      int r;
      t = $urandom_range(0, THREADS - 1);
      d = call_depth[t];
      r = $urandom_range(0, 99);
      op.thread = THREAD_W'(t);
      op.func   = FUNC_W'($urandom);
      op.frame  = rand_frame();
      if (r < 40) begin
         op = nested_push(t);
      end else if (r < 65) begin
         op.mode = OP_CHK_POP;
         if (d > 0) begin
            rec_bits = call_mem[t][d-1];
            if ($urandom_range(0, 9) == 0)
               rec_bits[$urandom_range(0, 63)] ^= 1'b1;
            {op.func, op.frame} = rec_bits;
         end
      end else if (r < 72) begin
         // unwind to an older frame, possibly an exact match
         op.mode = OP_PUSH;
         if (d > 0)
            op.frame = call_mem[t][$urandom_range(0, d - 1)].frame;
      end else if (r < 80) begin
         op.mode = OP_POP;
      end else if (r < 87) begin
         op.mode = MODE_W'($urandom_range(OP_PEEK, MODE_SPARE_LAST));
      end else if (r < 89) begin
         op.mode = OP_CLEAR;
      end else begin
         op.mode = MODE_W'($urandom);
      end
      return op;
   endfunction

   function automatic int sender_gap();
      int g;
      g = 0;
      while (g < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct)
         g++;
      return g;
   endfunction

   function automatic void add_row(input logic [MODE_W-1:0] mode, input int thread,
                                   input logic [FUNC_W-1:0] func,
                                   input logic [FRAME_W-1:0] frame, input int reps);
      directed_row_type row;
      row.op    = {mode, THREAD_W'(thread), func, frame};
      row.reps  = reps;
      row.known = 1'b0;
      row.want  = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_known(input logic [MODE_W-1:0] mode, input int thread,
                                     input logic [FUNC_W-1:0] func,
                                     input logic [FRAME_W-1:0] frame,
                                     input status_type st, input logic empty,
                                     input logic [FUNC_W-1:0] top_func,
                                     input logic [FRAME_W-1:0] top_frame,
                                     input logic [PRUNE_W-1:0] pruned);
      directed_row_type row;
      row.op    = {mode, THREAD_W'(thread), func, frame};
      row.reps  = 1;
      row.known = 1'b1;
      row.want  = {st, empty, top_func, top_frame, pruned};
      directed_rows = {directed_rows, row};
   endfunction

   task automatic offer_op(input call_op_type op, input bit known,
                           input stack_result_type want);
      int gap;
      stack_result_type res;
      gap = sender_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= op.mode;
      req_ch.thread_index <= op.thread;
      req_ch.func_id      <= op.func;
      req_ch.frame_base   <= op.frame;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      res = apply_call_op(op);
      if (known)
         res = want;
      pending_results = {pending_results, res};
      n_items++;
      status_seen[int'(res.status)]++;
      if (int'(res.pruned_count) > max_pruned)
         max_pruned = int'(res.pruned_count);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // receiver: random ready, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= hold_asked;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing expected, status %0d top %0h/%0h",
                     $time, rsp_ch.status, rsp_ch.top_func, rsp_ch.top_frame);
         end else begin
            oldest = pending_results.pop_front();
            check_field("status", 64'(oldest.status), 64'(rsp_ch.status));
            check_field("is_empty", 64'(oldest.is_empty), 64'(rsp_ch.is_empty));
            check_field("top_func", 64'(oldest.top_func), 64'(rsp_ch.top_func));
            check_field("top_frame", 64'(oldest.top_frame), 64'(rsp_ch.top_frame));
            check_field("pruned_count", 64'(oldest.pruned_count),
                        64'(rsp_ch.pruned_count));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, pending_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      call_op_type op;
      int t;
      req_ch.valid        = 1'b0;
      req_ch.mode         = '0;
      req_ch.thread_index = '0;
      req_ch.func_id      = '0;
      req_ch.frame_base   = '0;
      foreach (call_depth[i])
         call_depth[i] = 0;

      add_known(OP_PEEK, 0, '0, '0, ST_OK, 1'b1, '0, '0, '0);
      add_known(OP_POP, 0, '0, '0, ST_UNDERFLOW, 1'b1, '0, '0, '0);
      add_known(OP_CHK_POP, 7, '1, '1, ST_UNDERFLOW, 1'b1, '0, '0, '0);
      add_known(OP_PUSH, 0, '1, '1, ST_OK, 1'b0, '1, '1, '0);
      add_known(OP_PUSH, 0, '0, '0, ST_OK, 1'b0, '0, '0, '0);
      // equal frame base counts as stale
      add_known(OP_PUSH, 0, 16'h0001, '0, ST_OK, 1'b0, 16'h0001, '0, 7'd1);
      add_known(OP_CHK_POP, 0, 16'h0001, '0, ST_OK, 1'b0, '1, '1, '0);
      add_known(OP_CHK_POP, 0, 16'h1234, 48'h5, ST_MISMATCH, 1'b1, '0, '0, '0);
      add_row(OP_PUSH, 7, 16'hA5A5, 48'h8000_0000_0000, 1);
      add_row(OP_PUSH, 7, 16'h5A5A, 48'h7FFF_FFFF_FFFF, 1);
      add_row(OP_PEEK, 7, '0, '0, 1);
      add_row(MODE_SPARE_FIRST, 7, '1, '1, 1);
      add_row(MODE_SPARE_LAST, 7, '0, '0, 1);
      add_row(OP_CHK_POP, 7, 16'h5A5A, 48'h7FFF_FFFF_FFFE, 1);
      add_known(OP_PUSH, 7, 16'h00FF, '1, ST_OK, 1'b0, 16'h00FF, '1, 7'd1);
      add_row(OP_PUSH, 3, 16'h1111, 48'h0000_0000_1000, 1);
      add_known(OP_CLEAR, 3, '0, '0, ST_OK, 1'b1, '0, '0, '0);
      add_known(OP_PEEK, 7, '0, '0, ST_OK, 1'b1, '0, '0, '0);
      // fill thread 2 with strictly falling frames, overflow it, then prune it with a maximal frame
      add_row(OP_PUSH, 2, 16'h0100, '1, DEPTH);
      add_row(OP_PUSH, 2, 16'hBEEF, '0, 1);
      add_known(OP_PUSH, 2, 16'hCAFE, '1, ST_OK, 1'b0, 16'hCAFE, '1, PRUNE_W'(DEPTH));
      add_known(OP_POP, 2, '0, '0, ST_OK, 1'b1, '0, '0, '0);
      add_known(OP_POP, 2, '0, '0, ST_UNDERFLOW, 1'b1, '0, '0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (int k = 0; k < row.reps; k++) begin
            op = row.op;
            op.func  = op.func + FUNC_W'(k);
            op.frame = op.frame - FRAME_W'(k);
            offer_op(op, row.known, row.want);
         end
      end
      drain_results();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 80 : 0;
         rx_idle_pct <= (ph == 0) ? 80 : (ph == 1) ? 8 : 0;
         // deep fill: reset the thread with a maximal base, descend to full, overflow
         t = $urandom_range(0, THREADS - 1);
         op = {OP_PUSH, THREAD_W'(t), FUNC_W'($urandom), {FRAME_W{1'b1}}};
         offer_op(op, 1'b0, '0);
         while (call_depth[t] < DEPTH)
            offer_op(nested_push(t), 1'b0, '0);
         offer_op(nested_push(t), 1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 100)
               hold_asked <= hold_asked + 1;
            if (ph == 1 && n == 200)
               drain_results();
            offer_op(pick_call_op(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d items, %0d results: ok %0d, mismatch %0d, underflow %0d, %s",
               n_items, n_checked, status_seen[ST_OK], status_seen[ST_MISMATCH],
               status_seen[ST_UNDERFLOW], "plus overflows below");
      $display("overflow %0d, longest prune %0d, deepest stack %0d of %0d",
               status_seen[ST_OVERFLOW], max_pruned, peak_depth, DEPTH);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
